FILE: rtl/core/dmp_pkg.sv
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types and constants of the display mode and palette register file:
// port codes, bus function codes and the decoded command word.
// ----------------------------------------------------------------------------
package dmp_pkg;

  // bus function codes
  localparam logic [1:0] FUNC_WRITE       = 2'd0;
  localparam logic [1:0] FUNC_STATUS_FULL = 2'd1;
  localparam logic [1:0] FUNC_STATUS_MM   = 2'd2;

  // low address byte of each register port
  localparam logic [7:0] PORT_GATE    = 8'h08;
  localparam logic [7:0] PORT_MODE    = 8'hce;
  localparam logic [7:0] PORT_BORDER  = 8'hcf;
  localparam logic [7:0] PORT_PALETTE = 8'hf0;

  // high address byte sub-selects of the border port
  localparam logic [7:0] SUB_BORDER = 8'h06;
  localparam logic [7:0] SUB_SUPER  = 8'h07;

  // register reset values
  localparam logic [3:0] MODE_RESET = 4'h8;
  localparam logic [3:0] PAL0_RESET = 4'h9;
  localparam logic [3:0] PAL1_RESET = 4'hf;
  localparam logic [3:0] PAL2_RESET = 4'h9;
  localparam logic [3:0] PAL3_RESET = 4'hf;

  // mode bits
  localparam int unsigned MODE_COMPAT_BIT = 3;
  localparam logic [2:0]  MODE_UNDOC      = 3'b111;

  // depth of the command queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // decoded operation
  typedef enum logic [3:0] {
    OP_NONE,
    OP_STATUS,
    OP_GATE,
    OP_MODE,
    OP_BORDER,
    OP_SUPER,
    OP_PAL_GROUP,
    OP_PAL_ENTRY
  } op_t;

  // command word passed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] status;    // status byte without the superimpose bit
    logic       mm_form;   // memory-mapped status form
    logic [3:0] value;
    logic [1:0] idx;
  } cmd_t;

endpackage

FILE: rtl/core/dmp_front.sv
// ----------------------------------------------------------------------------
// dmp_front
// Front end: classifies each incoming bus word into a command word and
// pushes it into the command queue.
// ----------------------------------------------------------------------------
module dmp_front (
  input  logic          req_valid,
  input  logic [1:0]    func,
  input  logic [15:0]   bus_address,
  input  logic [7:0]    write_byte,
  input  logic          hblank_in,
  input  logic          vblank_in,
  input  logic          hsync_in,
  input  logic          vsync_in,
  input  logic          tempo_in,
  input  logic          compat_switch_in,
  input  logic          queue_full,
  output logic          req_stall,
  output logic          push,
  output dmp_pkg::cmd_t push_cmd
);
  import dmp_pkg::*;

  logic [7:0] low_byte;
  logic [7:0] high_byte;

  assign low_byte  = bus_address[7:0];
  assign high_byte = bus_address[15:8];

  // accept while the queue has room
  assign req_stall = queue_full;
  assign push      = req_valid && !queue_full;

  // classify the bus word
  always_comb begin
    push_cmd         = '0;
    push_cmd.op      = OP_NONE;
    push_cmd.mm_form = (func == FUNC_STATUS_MM);
    push_cmd.idx     = write_byte[5:4];
    push_cmd.value   = write_byte[3:0];
    unique case (func)
      FUNC_STATUS_FULL: begin
        push_cmd.op     = OP_STATUS;
        push_cmd.status = {hblank_in, vblank_in, hsync_in, vsync_in,
                           2'b00, compat_switch_in, tempo_in};
      end
      FUNC_STATUS_MM: begin
        push_cmd.op     = OP_STATUS;
        push_cmd.status = {hblank_in, 6'b000000, tempo_in};
      end
      FUNC_WRITE: begin
        unique case (low_byte)
          PORT_GATE: begin
            push_cmd.op    = OP_GATE;
            push_cmd.value = {3'b000, write_byte[0]};
          end
          PORT_MODE: push_cmd.op = OP_MODE;
          PORT_BORDER: begin
            if (high_byte == SUB_BORDER) begin
              push_cmd.op = OP_BORDER;
            end else if (high_byte == SUB_SUPER) begin
              push_cmd.op    = OP_SUPER;
              push_cmd.value = {3'b000, write_byte[7]};
            end
          end
          PORT_PALETTE: begin
            if (write_byte[6]) begin
              push_cmd.op    = OP_PAL_GROUP;
              push_cmd.value = {2'b00, write_byte[1:0]};
            end else begin
              push_cmd.op = OP_PAL_ENTRY;
            end
          end
          default: push_cmd.op = OP_NONE;
        endcase
      end
      default: push_cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/dmp_queue.sv
// ----------------------------------------------------------------------------
// dmp_queue
// Short command queue between front and back; push and pop may happen in
// the same cycle.
// ----------------------------------------------------------------------------
module dmp_queue #(
  parameter int unsigned DEPTH = dmp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dmp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output dmp_pkg::cmd_t head_cmd
);
  import dmp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = entries[rd_ptr];

  // pointer wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/dmp_back.sv
// ----------------------------------------------------------------------------
// dmp_back
// Back end: executes queued commands against the register file and holds
// the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module dmp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  dmp_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic [7:0]    read_data,
  output logic [3:0]    mode_out,
  output logic [3:0]    border_out,
  output logic [1:0]    pal_group_out,
  output logic [3:0]    pal0_out,
  output logic [3:0]    pal1_out,
  output logic [3:0]    pal2_out,
  output logic [3:0]    pal3_out,
  output logic          superimpose_out,
  output logic          gate_out,
  output logic          screen_changed,
  output logic          border_changed
);
  import dmp_pkg::*;

  // register file
  logic [3:0] mode_reg;
  logic [3:0] border_reg;
  logic [1:0] pal_group_reg;
  logic [3:0] palette_regs [4];
  logic       superimpose_reg;
  logic       gate_reg;

  logic [3:0] mode_next;
  logic [3:0] border_next;
  logic [1:0] pal_group_next;
  logic [3:0] palette_next [4];
  logic       superimpose_next;
  logic       gate_next;

  logic [7:0] read_data_next;
  logic       screen_next;
  logic       border_chg_next;
  logic       pal_changed;
  logic       undoc;

  // take a command whenever the result slot is free or being emptied
  assign pop   = !queue_empty && (!rsp_valid || !rsp_stall);
  assign undoc = (mode_reg[2:0] == MODE_UNDOC);

  // execute the head command
  always_comb begin
    mode_next        = mode_reg;
    border_next      = border_reg;
    pal_group_next   = pal_group_reg;
    palette_next     = palette_regs;
    superimpose_next = superimpose_reg;
    gate_next        = gate_reg;
    read_data_next   = '0;
    screen_next      = 1'b0;
    border_chg_next  = 1'b0;
    pal_changed      = 1'b0;
    unique case (head_cmd.op)
      OP_STATUS: begin
        read_data_next    = head_cmd.status;
        read_data_next[2] = superimpose_reg;
      end
      OP_GATE:  gate_next        = head_cmd.value[0];
      OP_SUPER: superimpose_next = head_cmd.value[0];
      OP_MODE: begin
        mode_next   = head_cmd.value;
        screen_next = (head_cmd.value != mode_reg);
      end
      OP_BORDER: begin
        border_next     = head_cmd.value;
        border_chg_next = (head_cmd.value != border_reg);
      end
      OP_PAL_GROUP: begin
        pal_group_next = head_cmd.value[1:0];
        pal_changed    = (head_cmd.value[1:0] != pal_group_reg);
      end
      OP_PAL_ENTRY: begin
        palette_next[head_cmd.idx] = head_cmd.value;
        // undocumented mode mirrors the outer entries inward
        if (undoc && head_cmd.idx == 2'd0) begin
          palette_next[1] = head_cmd.value;
        end
        if (undoc && head_cmd.idx == 2'd3) begin
          palette_next[2] = head_cmd.value;
        end
        pal_changed = (palette_next[0] != palette_regs[0]) ||
                      (palette_next[1] != palette_regs[1]) ||
                      (palette_next[2] != palette_regs[2]) ||
                      (palette_next[3] != palette_regs[3]);
      end
      default: ;
    endcase
    if (pal_changed && !mode_reg[MODE_COMPAT_BIT]) begin
      screen_next = 1'b1;
    end
  end

  // register file update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_RESET;
      border_reg      <= '0;
      pal_group_reg   <= '0;
      palette_regs[0] <= PAL0_RESET;
      palette_regs[1] <= PAL1_RESET;
      palette_regs[2] <= PAL2_RESET;
      palette_regs[3] <= PAL3_RESET;
      superimpose_reg <= 1'b0;
      gate_reg        <= 1'b0;
    end else if (pop) begin
      mode_reg        <= mode_next;
      border_reg      <= border_next;
      pal_group_reg   <= pal_group_next;
      palette_regs    <= palette_next;
      superimpose_reg <= superimpose_next;
      gate_reg        <= gate_next;
    end
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (pop) begin
      read_data      <= read_data_next;
      screen_changed <= screen_next;
      border_changed <= border_chg_next;
    end
  end

  // register contents change only when a new result is loaded
  assign mode_out        = mode_reg;
  assign border_out      = border_reg;
  assign pal_group_out   = pal_group_reg;
  assign pal0_out        = palette_regs[0];
  assign pal1_out        = palette_regs[1];
  assign pal2_out        = palette_regs[2];
  assign pal3_out        = palette_regs[3];
  assign superimpose_out = superimpose_reg;
  assign gate_out        = gate_reg;

endmodule

FILE: rtl/core/display_mode_palette_register_file_top.sv
// An accepted word is written into the command queue; the back end then executes it and registers its result.
// Throughput: one word per cycle; while a result waits to be taken the
// two-entry command queue absorbs two more words, then the input stalls.
// Reset (rst, synchronous): mode 8, border 0, palette group 0, palette
// 9/15/9/15, superimpose and gate clear, queue and result slot empty.
// ----------------------------------------------------------------------------
// display_mode_palette_register_file_top
// Display mode and palette register file: front decoder, command queue and
// back end that updates the registers and reports status.
// ----------------------------------------------------------------------------
module display_mode_palette_register_file_top #(
  parameter int unsigned QUEUE_DEPTH = dmp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_byte,
  input  logic        hblank_in,
  input  logic        vblank_in,
  input  logic        hsync_in,
  input  logic        vsync_in,
  input  logic        tempo_in,
  input  logic        compat_switch_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  read_data,
  output logic [3:0]  mode_out,
  output logic [3:0]  border_out,
  output logic [1:0]  pal_group_out,
  output logic [3:0]  pal0_out,
  output logic [3:0]  pal1_out,
  output logic [3:0]  pal2_out,
  output logic [3:0]  pal3_out,
  output logic        superimpose_out,
  output logic        gate_out,
  output logic        screen_changed,
  output logic        border_changed
);
  import dmp_pkg::*;

  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // decode
  dmp_front u_front (
    .req_valid        (req_valid),
    .func             (func),
    .bus_address      (bus_address),
    .write_byte       (write_byte),
    .hblank_in        (hblank_in),
    .vblank_in        (vblank_in),
    .hsync_in         (hsync_in),
    .vsync_in         (vsync_in),
    .tempo_in         (tempo_in),
    .compat_switch_in (compat_switch_in),
    .queue_full       (queue_full),
    .req_stall        (req_stall),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // command queue
  dmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head_cmd (head_cmd)
  );

  // execute
  dmp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_empty     (queue_empty),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .read_data       (read_data),
    .mode_out        (mode_out),
    .border_out      (border_out),
    .pal_group_out   (pal_group_out),
    .pal0_out        (pal0_out),
    .pal1_out        (pal1_out),
    .pal2_out        (pal2_out),
    .pal3_out        (pal3_out),
    .superimpose_out (superimpose_out),
    .gate_out        (gate_out),
    .screen_changed  (screen_changed),
    .border_changed  (border_changed)
  );

endmodule
